// ----- src/tlvp_pkg.sv -----
// tlvp_pkg: shared types and constants for the packet body parser
// no dependencies; imported by the parser, the result buffer and the top level

package tlvp_pkg;

    // default parameter values
    localparam int KEY_BYTES_DEF         = 4;
    localparam int INDEX_BYTES_DEF       = 2;
    localparam int FIXED_VALUE_BYTES_DEF = 4;

    // word limit after reset
    localparam logic [7:0] WORD_LIMIT_RST = 8'd32;

    // parse phase
    typedef enum logic [2:0] {
        PH_INDEX = 3'd0,
        PH_KEY   = 3'd1,
        PH_TYPE  = 3'd2,
        PH_LEN   = 3'd3,
        PH_VALUE = 3'd4,
        PH_HALT  = 3'd5
    } t_phase;

    // role of a byte in the body
    typedef enum logic [2:0] {
        FK_INDEX   = 3'd0,
        FK_KEY     = 3'd1,
        FK_TYPE    = 3'd2,
        FK_LEN     = 3'd3,
        FK_VALUE   = 3'd4,
        FK_IGNORED = 3'd5
    } t_field_kind;

    // parse status
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_TOO_MANY  = 3'd3,
        ST_TRUNCATED = 3'd4
    } t_status;

    // word type codes as they appear in the type byte
    localparam logic [7:0] TYPE_NONE   = 8'd0;
    localparam logic [7:0] TYPE_FLOAT  = 8'd2;
    localparam logic [7:0] TYPE_NESTED = 8'd5;

    // one tagged output word
    typedef struct packed {
        logic [2:0]  field_kind;
        logic [7:0]  word_number;
        logic [2:0]  word_kind;
        logic [15:0] value_length;
        logic [15:0] field_offset;
        logic [7:0]  byte_out;
        logic        word_end;
        logic        frame_end;
        logic [7:0]  words_seen;
        logic [2:0]  status;
    } t_result;

endpackage

// ----- src/tlvp_in_if.sv -----
// tlvp_in_if: input channel of the packet body parser, one body byte per word
// no dependencies

interface tlvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- src/tlvp_out_if.sv -----
// tlvp_out_if: output channel of the packet body parser, one tagged byte per word
// no dependencies

interface tlvp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  field_kind;
    logic [7:0]  word_number;
    logic [2:0]  word_kind;
    logic [15:0] value_length;
    logic [15:0] field_offset;
    logic [7:0]  byte_out;
    logic        word_end;
    logic        frame_end;
    logic [7:0]  words_seen;
    logic [2:0]  status;

    modport source (
        output valid, output field_kind, output word_number, output word_kind,
        output value_length, output field_offset, output byte_out, output word_end,
        output frame_end, output words_seen, output status, input ready
    );
    modport sink (
        input valid, input field_kind, input word_number, input word_kind,
        input value_length, input field_offset, input byte_out, input word_end,
        input frame_end, input words_seen, input status, output ready
    );
endinterface

// ----- src/tlv_packet_body_parser_top.sv -----
// tlv_packet_body_parser_top: packet body parser, top level
// depends on tlvp_pkg, tlvp_in_if, tlvp_out_if, tlvp_parser, tlvp_result_buf
//
// Usage:
//   i_in takes one body byte per word, data_byte plus last_byte on the final
//   byte of the body. o_out gives one tagged word per input byte: its role,
//   word number, type, value length, offset in the field, the byte itself,
//   word/frame end flags, the count of complete words and the status.
//   i_cfg_wr_en / i_cfg_wr_data write the word limit; write it only while idle.
//   Each result is registered in the result buffer on accept. Throughput: one
//   byte per cycle while the buffer has room; the parse state update is one
//   pass of logic between the parse registers and the result buffer.
//   Stall: a two-entry result buffer sits on the output; i_in.ready stays high
//   while it holds fewer than two words, so a stalled receiver backs the input
//   off after two words and nothing is dropped.
//   Reset: synchronous, active low; the word limit returns to 32, parse state
//   goes to the start of a body and the result buffer empties. Parse state
//   also returns to the start after each last byte.

module tlv_packet_body_parser_top #(
    parameter int KEY_BYTES         = tlvp_pkg::KEY_BYTES_DEF,
    parameter int INDEX_BYTES       = tlvp_pkg::INDEX_BYTES_DEF,
    parameter int FIXED_VALUE_BYTES = tlvp_pkg::FIXED_VALUE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    tlvp_in_if.sink    i_in,
    tlvp_out_if.source o_out
);
    import tlvp_pkg::*;

    logic       r_word_limit_v;
    logic [7:0] r_word_limit;
    logic       accept;
    logic       buf_ready;
    t_result    parse_res;
    t_result    out_res;

    // word limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_limit   <= WORD_LIMIT_RST;
            r_word_limit_v <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_word_limit   <= i_cfg_wr_data;
            r_word_limit_v <= 1'b1;
        end
    end

    assign i_in.ready = buf_ready;
    assign accept     = i_in.valid && buf_ready;

    // per-byte parse
    tlvp_parser #(
        .KEY_BYTES         (KEY_BYTES),
        .INDEX_BYTES       (INDEX_BYTES),
        .FIXED_VALUE_BYTES (FIXED_VALUE_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_in.data_byte),
        .i_last_byte  (i_in.last_byte),
        .i_word_limit (r_word_limit_v ? r_word_limit : WORD_LIMIT_RST),
        .o_result     (parse_res)
    );

    // output buffering
    tlvp_result_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (parse_res),
        .o_ready (buf_ready),
        .o_valid (o_out.valid),
        .i_pop   (o_out.ready),
        .o_data  (out_res)
    );

    // output fields
    assign o_out.field_kind   = out_res.field_kind;
    assign o_out.word_number  = out_res.word_number;
    assign o_out.word_kind    = out_res.word_kind;
    assign o_out.value_length = out_res.value_length;
    assign o_out.field_offset = out_res.field_offset;
    assign o_out.byte_out     = out_res.byte_out;
    assign o_out.word_end     = out_res.word_end;
    assign o_out.frame_end    = out_res.frame_end;
    assign o_out.words_seen   = out_res.words_seen;
    assign o_out.status       = out_res.status;

endmodule

// ----- src/tlvp_parser.sv -----
// tlvp_parser: per-byte parse state and tagging logic
// depends on tlvp_pkg

module tlvp_parser #(
    parameter int KEY_BYTES         = tlvp_pkg::KEY_BYTES_DEF,
    parameter int INDEX_BYTES       = tlvp_pkg::INDEX_BYTES_DEF,
    parameter int FIXED_VALUE_BYTES = tlvp_pkg::FIXED_VALUE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [7:0]        i_word_limit,
    output tlvp_pkg::t_result o_result
);
    import tlvp_pkg::*;

    localparam int     MIN_BODY = KEY_BYTES + 1;
    localparam int     BW       = $clog2(MIN_BODY + 1);
    localparam t_phase PH_START = (INDEX_BYTES > 0) ? PH_INDEX : PH_KEY;

    t_phase        r_phase, n_phase;
    logic [15:0]   r_fc, n_fc;
    logic [2:0]    r_kind, n_kind;
    logic [15:0]   r_len, n_len;
    logic [7:0]    r_total, n_total;
    logic [BW-1:0] r_bytes, n_bytes;
    t_status       r_err, n_err;

    logic [15:0]   fc_inc;
    t_field_kind   fk;
    logic [7:0]    wn;
    logic [2:0]    wk;
    logic [15:0]   vl;
    logic [15:0]   off;
    logic          wend;
    t_status       st;

    assign fc_inc = r_fc + 16'd1;

    // next state and tag for the byte at the input
    always_comb begin
        n_phase = r_phase;
        n_fc    = r_fc;
        n_kind  = r_kind;
        n_len   = r_len;
        n_total = r_total;
        n_err   = r_err;
        n_bytes = (r_bytes < BW'(MIN_BODY)) ? r_bytes + BW'(1) : r_bytes;
        fk      = FK_IGNORED;
        wn      = r_total;
        wk      = 3'd0;
        vl      = 16'd0;
        off     = 16'd0;
        wend    = 1'b0;

        unique case (r_phase)
            PH_INDEX: begin
                fk   = FK_INDEX;
                wn   = 8'd0;
                off  = r_fc;
                n_fc = fc_inc;
                if (fc_inc >= 16'(INDEX_BYTES)) begin
                    n_phase = PH_KEY;
                    n_fc    = 16'd0;
                end
            end
            PH_KEY: begin
                if (r_fc == 16'd0 && r_total >= i_word_limit) begin
                    // limit reached before a new word starts
                    n_err   = ST_TOO_MANY;
                    n_phase = PH_HALT;
                    n_fc    = 16'd0;
                    n_kind  = 3'd0;
                    n_len   = 16'd0;
                end else begin
                    fk   = FK_KEY;
                    off  = r_fc;
                    n_fc = fc_inc;
                    if (fc_inc >= 16'(KEY_BYTES)) begin
                        n_phase = PH_TYPE;
                        n_fc    = 16'd0;
                    end
                end
            end
            PH_TYPE: begin
                if (i_data_byte > TYPE_NESTED) begin
                    n_err   = ST_BAD_TYPE;
                    n_phase = PH_HALT;
                    n_fc    = 16'd0;
                    n_kind  = 3'd0;
                    n_len   = 16'd0;
                end else begin
                    fk     = FK_TYPE;
                    n_kind = i_data_byte[2:0];
                    n_fc   = 16'd0;
                    if (i_data_byte == TYPE_NONE) begin
                        n_len = 16'd0;
                        wend  = 1'b1;
                    end else if (i_data_byte <= TYPE_FLOAT) begin
                        n_len   = 16'(FIXED_VALUE_BYTES);
                        n_phase = PH_VALUE;
                    end else begin
                        n_len   = 16'd0;
                        n_phase = PH_LEN;
                    end
                    wk = i_data_byte[2:0];
                    vl = n_len;
                end
            end
            PH_LEN: begin
                fk    = FK_LEN;
                off   = r_fc;
                n_len = {r_len[7:0], i_data_byte};
                n_fc  = fc_inc;
                wk    = r_kind;
                if (fc_inc >= 16'd2) begin
                    vl   = n_len;
                    n_fc = 16'd0;
                    if (n_len == 16'd0) begin
                        wend = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                fk   = FK_VALUE;
                off  = r_fc;
                wk   = r_kind;
                vl   = r_len;
                n_fc = fc_inc;
                if (fc_inc >= r_len) begin
                    wend = 1'b1;
                end
            end
            default: begin
                wk = r_kind;
                vl = r_len;
            end
        endcase

        // word complete: back to the next key
        if (wend) begin
            n_total = r_total + 8'd1;
            n_phase = PH_KEY;
            n_fc    = 16'd0;
            n_kind  = 3'd0;
            n_len   = 16'd0;
        end

        // status, with end-of-body checks
        st = n_err;
        if (i_last_byte) begin
            if (n_bytes < BW'(MIN_BODY)) begin
                st = ST_TOO_SHORT;
            end else if (n_err == ST_OK && !(n_phase == PH_KEY && n_fc == 16'd0)) begin
                st = ST_TRUNCATED;
            end
        end
    end

    // tagged result
    always_comb begin
        o_result.field_kind   = fk;
        o_result.word_number  = wn;
        o_result.word_kind    = wk;
        o_result.value_length = vl;
        o_result.field_offset = off;
        o_result.byte_out     = i_data_byte;
        o_result.word_end     = wend;
        o_result.frame_end    = i_last_byte;
        o_result.words_seen   = n_total;
        o_result.status       = st;
    end

    // parse state, cleared on reset and after the last byte of a body
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase <= PH_START;
            r_fc    <= 16'd0;
            r_kind  <= 3'd0;
            r_len   <= 16'd0;
            r_total <= 8'd0;
            r_bytes <= '0;
            r_err   <= ST_OK;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_kind  <= n_kind;
            r_len   <= n_len;
            r_total <= n_total;
            r_bytes <= n_bytes;
            r_err   <= n_err;
        end
    end

endmodule

// ----- src/tlvp_result_buf.sv -----
// tlvp_result_buf: two-entry result buffer between the parser and the output channel
// depends on tlvp_pkg

module tlvp_result_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tlvp_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_pop,
    output tlvp_pkg::t_result o_data
);
    import tlvp_pkg::*;

    t_result    r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop_ok;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_entry[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop_ok};
        end
    end

endmodule
